// ----- hdl/tlfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tlfs_pkg: shared types and constants of the three-level feedback scheduler
// Request, command and response beats, action and level codes, register map.
// ----------------------------------------------------------------------------
package tlfs_pkg;

   // fixed field widths
   localparam int unsigned JOB_W      = 3;
   localparam int unsigned ACTION_W   = 2;
   localparam int unsigned LEVEL_W    = 2;
   localparam int unsigned SLICE_W    = 8;
   localparam int unsigned NUM_LEVELS = 3;
   localparam int unsigned MAX_JOBS   = 8;

   // register map and reset values
   localparam logic REG_HIGH_SLICES   = 1'b0;
   localparam logic REG_MEDIUM_SLICES = 1'b1;
   localparam logic [SLICE_W-1:0] HIGH_SLICES_RESET   = 8'd2;
   localparam logic [SLICE_W-1:0] MEDIUM_SLICES_RESET = 8'd6;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD      = 2'd0,
      ACT_DISPATCH = 2'd1,
      ACT_EXPIRE   = 2'd2,
      ACT_DONE     = 2'd3
   } action_type;

   typedef enum logic [LEVEL_W-1:0] {
      LVL_HIGH = 2'd0,
      LVL_MED  = 2'd1,
      LVL_LOW  = 2'd2
   } level_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_REJECT   = 3'd1,
      OP_DISPATCH = 3'd2,
      OP_EXPIRE   = 3'd3,
      OP_DONE     = 3'd4
   } op_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [JOB_W-1:0]    job_id;
   } req_type;

   typedef struct packed {
      op_type           op;
      logic [JOB_W-1:0] job_id;
   } cmd_type;

   typedef struct packed {
      logic               dispatched;
      logic [JOB_W-1:0]   dispatch_job;
      logic [LEVEL_W-1:0] dispatch_level;
      logic               off_valid;
      logic [JOB_W-1:0]   off_job;
      logic [LEVEL_W-1:0] off_level;
      logic               all_done;
      logic               error;
   } rsp_type;

endpackage

// ----- hdl/tlfs_front.sv -----
// ----------------------------------------------------------------------------
// tlfs_front: request intake and classification
// Accepts a request beat, decodes the action and rejects out-of-range job ids.
// ----------------------------------------------------------------------------
module tlfs_front (
   input  logic             start,
   input  tlfs_pkg::req_type req,
   input  logic             queue_full,
   output logic             busy,
   output logic             push_en,
   output tlfs_pkg::cmd_type cmd
);

   // hold off new beats while the queue is full
   assign busy    = queue_full;
   assign push_en = start && !queue_full;

   // decode the action into a back-end operation
   always_comb begin
      cmd.job_id = req.job_id;
      case (tlfs_pkg::action_type'(req.action))
         tlfs_pkg::ACT_ADD: begin
            if (32'(req.job_id) >= tlfs_pkg::MAX_JOBS) begin
               cmd.op = tlfs_pkg::OP_REJECT;
            end else begin
               cmd.op = tlfs_pkg::OP_ADD;
            end
         end
         tlfs_pkg::ACT_DISPATCH: cmd.op = tlfs_pkg::OP_DISPATCH;
         tlfs_pkg::ACT_EXPIRE:   cmd.op = tlfs_pkg::OP_EXPIRE;
         tlfs_pkg::ACT_DONE:     cmd.op = tlfs_pkg::OP_DONE;
         default:                cmd.op = tlfs_pkg::OP_REJECT;
      endcase
   end

endmodule

// ----- hdl/tlfs_queue.sv -----
// ----------------------------------------------------------------------------
// tlfs_queue: two-entry command queue between front and back
// Registered output; the back pops one beat per cycle whenever one is held.
// ----------------------------------------------------------------------------
module tlfs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  tlfs_pkg::cmd_type push_cmd,
   input  logic             pop_en,
   output logic             full,
   output logic             not_empty,
   output tlfs_pkg::cmd_type head_cmd
);

   tlfs_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_en  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push_en} - {1'b0, pop_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/tlfs_back.sv -----
// ----------------------------------------------------------------------------
// tlfs_back: scheduling engine
// Holds the three job rings and the running job, executes one command per
// cycle and registers the response beat.
// ----------------------------------------------------------------------------
module tlfs_back #(
   parameter int unsigned RING_DEPTH = 8,
   parameter int unsigned COUNT_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  tlfs_pkg::cmd_type                 cmd,
   input  logic [tlfs_pkg::SLICE_W-1:0]      high_slices,
   input  logic [tlfs_pkg::SLICE_W-1:0]      medium_slices,
   output logic                              rsp_strobe,
   output tlfs_pkg::rsp_type                 rsp_data
);

   localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
   localparam int unsigned CMP_W =
      (COUNT_BITS > tlfs_pkg::SLICE_W) ? COUNT_BITS : tlfs_pkg::SLICE_W;
   localparam logic [FILL_W-1:0]     FILL_MAX  = FILL_W'(RING_DEPTH);
   localparam logic [PTR_W-1:0]      PTR_LAST  = PTR_W'(RING_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // ring storage, contents undefined until written
   logic [tlfs_pkg::JOB_W-1:0] job_mem_ff [tlfs_pkg::NUM_LEVELS][RING_DEPTH];
   logic [COUNT_BITS-1:0]      cnt_mem_ff [tlfs_pkg::NUM_LEVELS][RING_DEPTH];

   logic [PTR_W-1:0]  head_ff [tlfs_pkg::NUM_LEVELS];
   logic [PTR_W-1:0]  tail_ff [tlfs_pkg::NUM_LEVELS];
   logic [FILL_W-1:0] fill_ff [tlfs_pkg::NUM_LEVELS];

   logic                       run_valid_ff, run_valid_in;
   logic [tlfs_pkg::JOB_W-1:0] run_job_ff, run_job_in;
   logic [COUNT_BITS-1:0]      run_count_ff, run_count_in;

   logic              rsp_strobe_ff;
   tlfs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                       push_en, pop_en;
   tlfs_pkg::level_type        push_lvl, pop_lvl, ran_lvl;
   logic [tlfs_pkg::JOB_W-1:0] push_job, pop_job;
   logic [COUNT_BITS-1:0]      push_cnt, pop_cnt;
   logic [CMP_W-1:0]           cmp_count, cmp_high, cmp_med;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign cmp_count = CMP_W'(run_count_ff);
   assign cmp_high  = CMP_W'(high_slices);
   assign cmp_med   = CMP_W'(medium_slices);

   // pick the highest non-empty ring and read its head
   always_comb begin
      if (fill_ff[tlfs_pkg::LVL_HIGH] != '0) begin
         pop_lvl = tlfs_pkg::LVL_HIGH;
      end else if (fill_ff[tlfs_pkg::LVL_MED] != '0) begin
         pop_lvl = tlfs_pkg::LVL_MED;
      end else begin
         pop_lvl = tlfs_pkg::LVL_LOW;
      end
      pop_job = job_mem_ff[pop_lvl][head_ff[pop_lvl]];
      pop_cnt = cnt_mem_ff[pop_lvl][head_ff[pop_lvl]];
   end

   // execute the command
   always_comb begin
      run_valid_in = run_valid_ff;
      run_job_in   = run_job_ff;
      run_count_in = run_count_ff;
      rsp_data_in  = '0;
      push_en      = 1'b0;
      pop_en       = 1'b0;
      push_lvl     = tlfs_pkg::LVL_HIGH;
      push_job     = cmd.job_id;
      push_cnt     = '0;
      ran_lvl      = tlfs_pkg::LVL_HIGH;
      case (cmd.op)
         tlfs_pkg::OP_ADD: begin
            if (fill_ff[tlfs_pkg::LVL_HIGH] == FILL_MAX) begin
               rsp_data_in.error = 1'b1;
            end else begin
               push_en = 1'b1;
            end
         end
         tlfs_pkg::OP_DISPATCH: begin
            if (run_valid_ff) begin
               rsp_data_in.error = 1'b1;
            end else if (fill_ff[pop_lvl] == '0) begin
               rsp_data_in.all_done = 1'b1;
            end else begin
               pop_en                     = 1'b1;
               run_valid_in               = 1'b1;
               run_job_in                 = pop_job;
               run_count_in               = (pop_cnt == COUNT_MAX) ? pop_cnt
                                                                   : pop_cnt + 1'b1;
               rsp_data_in.dispatched     = 1'b1;
               rsp_data_in.dispatch_job   = pop_job;
               rsp_data_in.dispatch_level = pop_lvl;
            end
         end
         tlfs_pkg::OP_EXPIRE: begin
            // demote by run count
            if (cmp_count < cmp_high) begin
               push_lvl = tlfs_pkg::LVL_HIGH;
               ran_lvl  = tlfs_pkg::LVL_HIGH;
            end else if (cmp_count == cmp_high) begin
               push_lvl = tlfs_pkg::LVL_MED;
               ran_lvl  = tlfs_pkg::LVL_HIGH;
            end else if (cmp_count < cmp_med) begin
               push_lvl = tlfs_pkg::LVL_MED;
               ran_lvl  = tlfs_pkg::LVL_MED;
            end else if (cmp_count == cmp_med) begin
               push_lvl = tlfs_pkg::LVL_LOW;
               ran_lvl  = tlfs_pkg::LVL_MED;
            end else begin
               push_lvl = tlfs_pkg::LVL_LOW;
               ran_lvl  = tlfs_pkg::LVL_LOW;
            end
            push_job = run_job_ff;
            push_cnt = run_count_ff;
            if (!run_valid_ff || fill_ff[push_lvl] == FILL_MAX) begin
               rsp_data_in.error = 1'b1;
            end else begin
               push_en               = 1'b1;
               run_valid_in          = 1'b0;
               rsp_data_in.off_valid = 1'b1;
               rsp_data_in.off_job   = run_job_ff;
               rsp_data_in.off_level = ran_lvl;
            end
         end
         tlfs_pkg::OP_DONE: begin
            // drop the running job
            if (!run_valid_ff) begin
               rsp_data_in.error = 1'b1;
            end else begin
               run_valid_in = 1'b0;
            end
         end
         default: begin
            rsp_data_in.error = 1'b1;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlfs_pkg::NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         run_valid_ff  <= 1'b0;
         run_job_ff    <= '0;
         run_count_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd_valid;
         if (cmd_valid) begin
            run_valid_ff <= run_valid_in;
            run_job_ff   <= run_job_in;
            run_count_ff <= run_count_in;
            if (push_en) begin
               tail_ff[push_lvl] <= next_slot(tail_ff[push_lvl]);
               fill_ff[push_lvl] <= fill_ff[push_lvl] + 1'b1;
            end
            if (pop_en) begin
               head_ff[pop_lvl] <= next_slot(head_ff[pop_lvl]);
               fill_ff[pop_lvl] <= fill_ff[pop_lvl] - 1'b1;
            end
         end
      end
   end

   // ring writes and response payload
   always_ff @(posedge clock) begin
      if (cmd_valid && push_en) begin
         job_mem_ff[push_lvl][tail_ff[push_lvl]] <= push_job;
         cnt_mem_ff[push_lvl][tail_ff[push_lvl]] <= push_cnt;
      end
      if (cmd_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ring fill never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= FILL_MAX && fill_ff[1] <= FILL_MAX && fill_ff[2] <= FILL_MAX)
      else $error("ring fill exceeds depth");

   // a beat never both starts and switches off a job
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_data_ff.dispatched && rsp_data_ff.off_valid))
      else $error("dispatch and switch-off in one beat");

   // a dispatch leaves a job running
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.dispatched |-> run_valid_ff)
      else $error("dispatched job not running");

   // a switch-off leaves nothing running
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.off_valid |-> !run_valid_ff)
      else $error("switched-off job still running");

   // an error beat carries no dispatch
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.error |-> !rsp_data_ff.dispatched)
      else $error("error beat flags a dispatch");

endmodule

// ----- hdl/three_level_feedback_scheduler.sv -----
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler: three-level feedback job scheduler
// Request front, two-entry command queue, scheduling back end, APB registers.
// ----------------------------------------------------------------------------
// Path: an accepted request beat is registered in the command queue, and the
//   back end registers its response strobe when it executes the queue head.
// Throughput: one request per cycle; the back end retires one queued command
//   each cycle, so busy only rises if the two-entry queue fills.
// Reset: synchronous; rings empty, no job running, high_slices 2,
//   medium_slices 6. The receiver cannot stall responses.
module three_level_feedback_scheduler #(
   parameter int unsigned RING_DEPTH = 8,
   parameter int unsigned COUNT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  tlfs_pkg::req_type req_data,
   // response channel
   output logic              rsp_strobe,
   output tlfs_pkg::rsp_type rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [tlfs_pkg::SLICE_W-1:0] high_slices_ff, medium_slices_ff;
   logic              csr_write;
   logic              push_en, queue_full, cmd_valid;
   tlfs_pkg::cmd_type push_cmd, head_cmd;

   // register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_slices_ff   <= tlfs_pkg::HIGH_SLICES_RESET;
         medium_slices_ff <= tlfs_pkg::MEDIUM_SLICES_RESET;
      end else if (csr_write) begin
         if (paddr[2] == tlfs_pkg::REG_HIGH_SLICES) begin
            high_slices_ff <= pwdata[tlfs_pkg::SLICE_W-1:0];
         end else begin
            medium_slices_ff <= pwdata[tlfs_pkg::SLICE_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == tlfs_pkg::REG_MEDIUM_SLICES) begin
         prdata = 32'(medium_slices_ff);
      end else begin
         prdata = 32'(high_slices_ff);
      end
   end

   tlfs_front u_front (
      .start      (start),
      .req        (req_data),
      .queue_full (queue_full),
      .busy       (busy),
      .push_en    (push_en),
      .cmd        (push_cmd)
   );

   tlfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_cmd  (push_cmd),
      .pop_en    (cmd_valid),
      .full      (queue_full),
      .not_empty (cmd_valid),
      .head_cmd  (head_cmd)
   );

   tlfs_back #(
      .RING_DEPTH (RING_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (head_cmd),
      .high_slices   (high_slices_ff),
      .medium_slices (medium_slices_ff),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data)
   );

endmodule

// ----- sim/tlfs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfs_checker: response predictor and scoreboard for the feedback scheduler
// Follows accepted request beats and register writes, predicts the response
// of every beat and compares it field by field with the response channel; checks register reads too.
// ----------------------------------------------------------------------------
module tlfs_checker #(
   parameter int unsigned RING_DEPTH = 8,
   parameter int unsigned COUNT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   input  logic              busy,
   input  tlfs_pkg::req_type req_data,
   // response channel
   input  logic              rsp_strobe,
   input  tlfs_pkg::rsp_type rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic [31:0]       prdata,
   input  logic              pready,
   // results for the testbench top
   output int unsigned       fail_count,
   output int unsigned       pending,
   output int unsigned       dispatch_seen,
   output int unsigned       off_seen,
   output int unsigned       idle_seen,
   output int unsigned       error_seen
);

   localparam logic [COUNT_BITS-1:0] RUN_MAX   = '1;
   localparam logic [2:0]            ADDR_HIGH = {tlfs_pkg::REG_HIGH_SLICES, 2'b00};
   localparam logic [2:0]            ADDR_MED  = {tlfs_pkg::REG_MEDIUM_SLICES, 2'b00};

   typedef struct packed {
      logic [tlfs_pkg::JOB_W-1:0] job;
      logic [COUNT_BITS-1:0]      runs;
   } slot_type;

   // predicted scheduler state
   slot_type                     ring_mem  [tlfs_pkg::NUM_LEVELS][RING_DEPTH];
   int unsigned                  ring_head [tlfs_pkg::NUM_LEVELS];
   int unsigned                  ring_tail [tlfs_pkg::NUM_LEVELS];
   int unsigned                  ring_fill [tlfs_pkg::NUM_LEVELS];
   logic                         run_valid;
   logic [tlfs_pkg::JOB_W-1:0]   run_job;
   logic [COUNT_BITS-1:0]        run_count;
   logic [tlfs_pkg::SLICE_W-1:0] high_slices;
   logic [tlfs_pkg::SLICE_W-1:0] medium_slices;
   tlfs_pkg::rsp_type            rsp_due [$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      dispatch_seen = 0;
      off_seen      = 0;
      idle_seen     = 0;
      error_seen    = 0;
   end

   // append a job to a ring, refuse when the ring is full
   function automatic bit enqueue_job(tlfs_pkg::level_type lvl,
                                      logic [tlfs_pkg::JOB_W-1:0] job,
                                      logic [COUNT_BITS-1:0] runs);
      if (ring_fill[lvl] >= RING_DEPTH)
         return 1'b0;
      ring_mem[lvl][ring_tail[lvl]] = '{job: job, runs: runs};
      ring_tail[lvl] = (ring_tail[lvl] + 1) % RING_DEPTH;
      ring_fill[lvl]++;
      return 1'b1;
   endfunction

   // apply one request beat to the predicted state and build its response
   function automatic tlfs_pkg::rsp_type schedule_beat(tlfs_pkg::req_type beat);
      tlfs_pkg::rsp_type     res;
      tlfs_pkg::level_type   src;
      tlfs_pkg::level_type   dest;
      tlfs_pkg::level_type   ran;
      bit                    found;
      slot_type              head_slot;
      res   = '0;
      src   = tlfs_pkg::LVL_HIGH;
      dest  = tlfs_pkg::LVL_HIGH;
      ran   = tlfs_pkg::LVL_HIGH;
      found = 1'b1;
      case (tlfs_pkg::action_type'(beat.action))
         tlfs_pkg::ACT_ADD: begin
            if (beat.job_id >= tlfs_pkg::MAX_JOBS ||
                !enqueue_job(tlfs_pkg::LVL_HIGH, beat.job_id, '0))
               res.error = 1'b1;
         end
         tlfs_pkg::ACT_DISPATCH: begin
            if (run_valid) begin
               res.error = 1'b1;
            end else begin
               // take the highest level that holds a job
               if (ring_fill[tlfs_pkg::LVL_HIGH] != 0)
                  src = tlfs_pkg::LVL_HIGH;
               else if (ring_fill[tlfs_pkg::LVL_MED] != 0)
                  src = tlfs_pkg::LVL_MED;
               else if (ring_fill[tlfs_pkg::LVL_LOW] != 0)
                  src = tlfs_pkg::LVL_LOW;
               else
                  found = 1'b0;
               if (!found) begin
                  res.all_done = 1'b1;
               end else begin
                  head_slot      = ring_mem[src][ring_head[src]];
                  ring_head[src] = (ring_head[src] + 1) % RING_DEPTH;
                  ring_fill[src]--;
                  run_valid = 1'b1;
                  run_job   = head_slot.job;
                  run_count = (head_slot.runs == RUN_MAX) ? head_slot.runs
                                                          : head_slot.runs + 1'b1;
                  res.dispatched     = 1'b1;
                  res.dispatch_job   = run_job;
                  res.dispatch_level = src;
               end
            end
         end
         tlfs_pkg::ACT_EXPIRE: begin
            if (!run_valid) begin
               res.error = 1'b1;
            end else begin
               // pick the requeue level from the run count
               if (run_count < high_slices) begin
                  dest = tlfs_pkg::LVL_HIGH;
                  ran  = tlfs_pkg::LVL_HIGH;
               end else if (run_count == high_slices) begin
                  dest = tlfs_pkg::LVL_MED;
                  ran  = tlfs_pkg::LVL_HIGH;
               end else if (run_count < medium_slices) begin
                  dest = tlfs_pkg::LVL_MED;
                  ran  = tlfs_pkg::LVL_MED;
               end else if (run_count == medium_slices) begin
                  dest = tlfs_pkg::LVL_LOW;
                  ran  = tlfs_pkg::LVL_MED;
               end else begin
                  dest = tlfs_pkg::LVL_LOW;
                  ran  = tlfs_pkg::LVL_LOW;
               end
               if (enqueue_job(dest, run_job, run_count)) begin
                  run_valid     = 1'b0;
                  res.off_valid = 1'b1;
                  res.off_job   = run_job;
                  res.off_level = ran;
               end else begin
                  res.error = 1'b1;
               end
            end
         end
         default: begin
            if (!run_valid)
               res.error = 1'b1;
            else
               run_valid = 1'b0;
         end
      endcase
      return res;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tlfs_pkg::rsp_type want;
      if (reset) begin
         for (int l = 0; l < tlfs_pkg::NUM_LEVELS; l++) begin
            ring_head[l] = 0;
            ring_tail[l] = 0;
            ring_fill[l] = 0;
         end
         run_valid     = 1'b0;
         run_job       = '0;
         run_count     = '0;
         high_slices   = tlfs_pkg::HIGH_SLICES_RESET;
         medium_slices = tlfs_pkg::MEDIUM_SLICES_RESET;
         rsp_due.delete();
      end else begin
         // match a response beat against the oldest prediction
         if (rsp_strobe) begin
            if (rsp_due.size() == 0) begin
               $display("%0t: response beat with nothing expected, expected none, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = rsp_due.pop_front();
               compare_field("dispatched", want.dispatched, rsp_data.dispatched);
               compare_field("dispatch_job", want.dispatch_job, rsp_data.dispatch_job);
               compare_field("dispatch_level", want.dispatch_level, rsp_data.dispatch_level);
               compare_field("off_valid", want.off_valid, rsp_data.off_valid);
               compare_field("off_job", want.off_job, rsp_data.off_job);
               compare_field("off_level", want.off_level, rsp_data.off_level);
               compare_field("all_done", want.all_done, rsp_data.all_done);
               compare_field("error", want.error, rsp_data.error);
            end
            dispatch_seen += rsp_data.dispatched;
            off_seen      += rsp_data.off_valid;
            idle_seen     += rsp_data.all_done;
            error_seen    += rsp_data.error;
         end
         // track register writes, check register reads
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr)
                  ADDR_HIGH: high_slices   = pwdata[tlfs_pkg::SLICE_W-1:0];
                  ADDR_MED:  medium_slices = pwdata[tlfs_pkg::SLICE_W-1:0];
                  default: ;
               endcase
            end else begin
               case (paddr)
                  ADDR_HIGH: compare_field("high_slices read", high_slices,
                                           prdata[tlfs_pkg::SLICE_W-1:0]);
                  ADDR_MED:  compare_field("medium_slices read", medium_slices,
                                           prdata[tlfs_pkg::SLICE_W-1:0]);
                  default: ;
               endcase
            end
         end
         // predict the response of an accepted request beat
         if (start && !busy)
            rsp_due.push_back(schedule_beat(req_data));
      end
      pending <= rsp_due.size();
   end

endmodule

// ----- sim/three_level_feedback_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_tb: top of the scheduler testbench
// Drives directed and random request beats in bursts under several slice
// settings, including a run-count saturation run; the checker scores them.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler_tb;

   localparam int unsigned RSP_LATENCY  = 2;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_BEATS = 256;
   localparam int unsigned NUM_PHASES   = 8;
   localparam int unsigned SAT_ROUNDS   = 258;
   localparam int unsigned REQ_W        = $bits(tlfs_pkg::req_type);
   localparam logic [2:0]  ADDR_HIGH    = {tlfs_pkg::REG_HIGH_SLICES, 2'b00};
   localparam logic [2:0]  ADDR_MED     = {tlfs_pkg::REG_MEDIUM_SLICES, 2'b00};

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   tlfs_pkg::req_type req_data = '0;
   logic              psel     = 1'b0;
   logic              penable  = 1'b0;
   logic              pwrite   = 1'b0;
   logic [2:0]        paddr    = '0;
   logic [31:0]       pwdata   = '0;
   logic              busy;
   logic              rsp_strobe;
   tlfs_pkg::rsp_type rsp_data;
   logic [31:0]       prdata;
   logic              pready;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned dispatch_seen;
   int unsigned off_seen;
   int unsigned idle_seen;
   int unsigned error_seen;
   int unsigned beats_sent = 0;
   int unsigned burst_left = 0;
   int unsigned settings   = 0;
   bit          gaps_on    = 1'b1;

   always #5 clock = ~clock;

   three_level_feedback_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   tlfs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending       (pending),
      .dispatch_seen (dispatch_seen),
      .off_seen      (off_seen),
      .idle_seen     (idle_seen),
      .error_seen    (error_seen)
   );

   function automatic tlfs_pkg::req_type make_beat(tlfs_pkg::action_type act,
                                                   logic [tlfs_pkg::JOB_W-1:0] job);
      tlfs_pkg::req_type beat;
      beat.action = act;
      beat.job_id = job;
      return beat;
   endfunction

   // send one request beat; open a new burst after a random gap when due
   task automatic send_beat(input tlfs_pkg::req_type beat);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            start    <= 1'b0;
            req_data <= REQ_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   // stop sending and wait until every response is back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   // one register access: setup cycle, access cycle, then release
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // write both slice limits with noisy upper bits, then read them back
   task automatic set_slices(input logic [tlfs_pkg::SLICE_W-1:0] high,
                             input logic [tlfs_pkg::SLICE_W-1:0] med_limit);
      logic [31:0] noise;
      noise = $urandom;
      csr_access(1'b1, ADDR_HIGH, {noise[31:tlfs_pkg::SLICE_W], high});
      noise = $urandom;
      csr_access(1'b1, ADDR_MED, {noise[31:tlfs_pkg::SLICE_W], med_limit});
      csr_access(1'b0, ADDR_HIGH, '0);
      csr_access(1'b0, ADDR_MED, '0);
      settings++;
   endtask

   // mostly dispatch then expire-or-done sequences and adds, with some raw noise beats
   task automatic random_traffic(input int unsigned beats, input int unsigned add_pct);
      int unsigned sent;
      int unsigned roll;
      sent = 0;
      while (sent < beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            send_beat(REQ_W'($urandom));
            sent++;
         end else if (roll < 10 + add_pct) begin
            send_beat(make_beat(tlfs_pkg::ACT_ADD, tlfs_pkg::JOB_W'($urandom)));
            sent++;
         end else begin
            send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, tlfs_pkg::JOB_W'($urandom)));
            // slip an add in so an expiry can meet a full ring
            if ($urandom_range(0, 9) < 3) begin
               send_beat(make_beat(tlfs_pkg::ACT_ADD, tlfs_pkg::JOB_W'($urandom)));
               sent++;
            end
            send_beat(make_beat(($urandom_range(0, 4) == 0) ? tlfs_pkg::ACT_DONE
                                                            : tlfs_pkg::ACT_EXPIRE,
                                tlfs_pkg::JOB_W'($urandom)));
            sent += 2;
         end
      end
   endtask

   // run-time guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("three_level_feedback_scheduler_tb: done, errors");
      $finish;
   end

   initial begin
      logic [tlfs_pkg::SLICE_W-1:0] high_list [NUM_PHASES];
      logic [tlfs_pkg::SLICE_W-1:0] med_list  [NUM_PHASES];
      logic [tlfs_pkg::SLICE_W-1:0] high;
      logic [tlfs_pkg::SLICE_W-1:0] med_limit;

      high_list = '{8'd2, 8'd1, 8'd1, 8'd255, 8'd0, 8'd200, 8'd3, 8'd0};
      med_list  = '{8'd6, 8'd1, 8'd255, 8'd255, 8'd0, 8'd5, 8'd9, 8'd0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset slice limits
      send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, 3'd0));   // all rings empty
      send_beat(make_beat(tlfs_pkg::ACT_EXPIRE, 3'd7));     // expire with nothing running
      send_beat(make_beat(tlfs_pkg::ACT_DONE, 3'd5));       // done with nothing running
      for (int j = 0; j < tlfs_pkg::MAX_JOBS; j++)
         send_beat(make_beat(tlfs_pkg::ACT_ADD, tlfs_pkg::JOB_W'(j)));
      send_beat(make_beat(tlfs_pkg::ACT_ADD, 3'd7));        // add to a full high ring
      send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, 3'd3));   // dispatch while a job runs
      send_beat(make_beat(tlfs_pkg::ACT_EXPIRE, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_DONE, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_DONE, 3'd0));       // drop a running job
      send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_EXPIRE, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_ADD, 3'd1));
      send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, 3'd0));
      send_beat(make_beat(tlfs_pkg::ACT_ADD, 3'd4));
      send_beat(make_beat(tlfs_pkg::ACT_EXPIRE, 3'd0));     // expire into a full ring
      send_beat(make_beat(tlfs_pkg::ACT_DONE, 3'd0));
      drain_responses();

      // saturation: empty the rings, then cycle one job past the count limit
      set_slices(8'd250, 8'd254);
      send_beat(make_beat(tlfs_pkg::ACT_DONE, 3'd0));
      repeat (3 * tlfs_pkg::MAX_JOBS + 1) begin
         send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, tlfs_pkg::JOB_W'($urandom)));
         send_beat(make_beat(tlfs_pkg::ACT_DONE, tlfs_pkg::JOB_W'($urandom)));
      end
      send_beat(make_beat(tlfs_pkg::ACT_ADD, 3'd5));
      repeat (SAT_ROUNDS) begin
         send_beat(make_beat(tlfs_pkg::ACT_DISPATCH, tlfs_pkg::JOB_W'($urandom)));
         send_beat(make_beat(tlfs_pkg::ACT_EXPIRE, tlfs_pkg::JOB_W'($urandom)));
      end
      drain_responses();

      // random phases over a spread of slice settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         high      = (p >= 6) ? tlfs_pkg::SLICE_W'($urandom) : high_list[p];
         med_limit = (p >= 6) ? tlfs_pkg::SLICE_W'($urandom) : med_list[p];
         set_slices(high, med_limit);
         gaps_on = ($urandom_range(0, 3) != 0);
         random_traffic(RANDOM_BEATS / NUM_PHASES, $urandom_range(15, 60));
         drain_responses();
      end

      $display("covered %0d request beats over %0d slice settings, saturation run included",
               beats_sent, settings);
      $display("responses: %0d dispatched, %0d switched off, %0d all done, %0d flagged",
               dispatch_seen, off_seen, idle_seen, error_seen);
      if (fail_count == 0 && pending == 0)
         $display("three_level_feedback_scheduler_tb: done, clean");
      else
         $display("three_level_feedback_scheduler_tb: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/tlfs_pkg.sv
hdl/tlfs_front.sv
hdl/tlfs_queue.sv
hdl/tlfs_back.sv
hdl/three_level_feedback_scheduler.sv
sim/tlfs_checker.sv
sim/three_level_feedback_scheduler_tb.sv
